// ----- hw/rtl/channel_activity_histogram_shader_macros.svh -----
// ----------------------------------------------------------------------------
// Channel activity histogram shader - assertion macros
// Shared concurrent assertion forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_ACTIVITY_HISTOGRAM_SHADER_MACROS_SVH
`define CHANNEL_ACTIVITY_HISTOGRAM_SHADER_MACROS_SVH

// Condition holds at every edge out of reset.
`define CHS_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define CHS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/chs_pkg.sv -----
// ----------------------------------------------------------------------------
// chs_pkg
// Types, codes and the glyph ramp for the channel activity histogram shader.
// ----------------------------------------------------------------------------
package chs_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  localparam logic [7:0] HIT_PATTERN = 8'h01;
  localparam logic [7:0] COUNT_MAX   = 8'hFF;
  localparam logic [3:0] LEVEL_MAX   = 4'd9;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] channel;
    logic [7:0] detector_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] hit_count;
    logic [3:0] shade_level;
    logic [6:0] glyph;
    logic [7:0] peak_count;
  } out_item_t;

  // Classified command passed from front end to back end.
  typedef struct packed {
    op_t        op;
    logic [6:0] channel;
    logic       in_range;
    logic       hit;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_UPDATE,
    BK_DIVIDE,
    BK_EMIT
  } back_state_t;

  // ASCII ramp " .:-=+*#%@"
  function automatic logic [6:0] glyph_of(input logic [3:0] level);
    logic [6:0] g;
    unique case (level)
      4'd0:    g = 7'h20;
      4'd1:    g = 7'h2E;
      4'd2:    g = 7'h3A;
      4'd3:    g = 7'h2D;
      4'd4:    g = 7'h3D;
      4'd5:    g = 7'h2B;
      4'd6:    g = 7'h2A;
      4'd7:    g = 7'h23;
      4'd8:    g = 7'h25;
      4'd9:    g = 7'h40;
      default: g = 7'h20;
    endcase
    return g;
  endfunction

  // Nonzero counts never shade as level 0; cap at the top of the ramp.
  function automatic logic [3:0] level_clamp(input logic [3:0] q);
    logic [3:0] l;
    priority if (q == 4'd0)      l = 4'd1;
    else if (q > LEVEL_MAX)      l = LEVEL_MAX;
    else                         l = q;
    return l;
  endfunction

endpackage

// ----- hw/rtl/chs_if.sv -----
// ----------------------------------------------------------------------------
// chs_if
// Valid/ready channel interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface chs_in_if;
  logic               valid;
  logic               ready;
  chs_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface chs_out_if;
  logic               valid;
  logic               ready;
  chs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/chs_front.sv -----
// ----------------------------------------------------------------------------
// chs_front
// Accepts input items, decodes op, range and hit, and queues the commands
// in a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module chs_front #(
  parameter int NUM_CHANNELS = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  chs_in_if.sink        in_if,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output chs_pkg::cmd_t cmd
);

  chs_pkg::cmd_t q_mem [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;
  chs_pkg::cmd_t cls;

  always_comb begin
    cls.op       = chs_pkg::op_t'(in_if.data.op);
    cls.channel  = in_if.data.channel;
    cls.in_range = ({2'b00, in_if.data.channel} < 9'(NUM_CHANNELS));
    cls.hit      = (cls.op == chs_pkg::OP_SAMPLE) &&
                   (in_if.data.detector_byte == chs_pkg::HIT_PATTERN);
  end

  assign in_if.ready = (cnt_r != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/chs_back.sv -----
// ----------------------------------------------------------------------------
// chs_back
// Executes one command at a time: count lookup and update, peak tracking,
// a four-step restoring divide for the shade level, and the result register.
// ----------------------------------------------------------------------------
`include "channel_activity_histogram_shader_macros.svh"

module chs_back #(
  parameter int NUM_CHANNELS = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  chs_pkg::cmd_t cmd,
  chs_out_if.source     out_if
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [7:0]              mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_r, vld_nxt;
  logic [7:0]              rd_data_r;
  logic                    rd_vld_r;

  chs_pkg::back_state_t    state_r, state_nxt;
  chs_pkg::cmd_t           cur_r, cur_nxt;
  logic [7:0]              count_r, count_nxt;
  logic [7:0]              peak_r, peak_nxt;
  logic [12:0]             rem_r, rem_nxt;
  logic [11:0]             div_r, div_nxt;
  logic [3:0]              quo_r, quo_nxt;
  logic [1:0]              step_r, step_nxt;
  logic [3:0]              lvl_r, lvl_nxt;
  logic                    out_valid_r, out_valid_nxt;
  chs_pkg::out_item_t      out_r, out_nxt;

  logic [7:0]              cmd_chan_ext, cur_chan_ext;
  logic [AW-1:0]           rd_addr, cur_addr;
  logic [7:0]              base, upd_count;
  logic                    bump, mem_we;

  assign cmd_chan_ext = {1'b0, cmd.channel};
  assign cur_chan_ext = {1'b0, cur_r.channel};
  assign rd_addr      = cmd_chan_ext[AW-1:0];
  assign cur_addr     = cur_chan_ext[AW-1:0];

  assign base      = rd_vld_r ? rd_data_r : 8'd0;
  assign bump      = cur_r.hit && cur_r.in_range && (base != chs_pkg::COUNT_MAX);
  assign upd_count = bump ? base + 8'd1 : base;

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    count_nxt     = count_r;
    peak_nxt      = peak_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    lvl_nxt       = lvl_r;
    vld_nxt       = vld_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    cmd_ready     = 1'b0;
    mem_we        = 1'b0;

    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      chs_pkg::BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cur_nxt   = cmd;
          state_nxt = chs_pkg::BK_UPDATE;
        end
      end

      chs_pkg::BK_UPDATE: begin
        lvl_nxt   = 4'd0;
        state_nxt = chs_pkg::BK_EMIT;
        if (cur_r.op == chs_pkg::OP_CLEAR) begin
          vld_nxt   = '0;
          peak_nxt  = 8'd0;
          count_nxt = 8'd0;
        end else begin
          count_nxt = cur_r.in_range ? upd_count : 8'd0;
          if (bump) begin
            mem_we            = 1'b1;
            vld_nxt[cur_addr] = 1'b1;
            if (upd_count > peak_r) begin
              peak_nxt = upd_count;
            end
          end
          // level = floor((18*count + peak) / (2*peak))
          if ((cur_r.op == chs_pkg::OP_READ) && cur_r.in_range &&
              (upd_count != 8'd0) && (peak_r != 8'd0)) begin
            rem_nxt   = {1'b0, upd_count, 4'b0000} + {4'b0000, upd_count, 1'b0} +
                        {5'b00000, peak_r};
            div_nxt   = {peak_r, 4'b0000};
            quo_nxt   = 4'd0;
            step_nxt  = 2'd3;
            state_nxt = chs_pkg::BK_DIVIDE;
          end
        end
      end

      chs_pkg::BK_DIVIDE: begin
        if (rem_r >= {1'b0, div_r}) begin
          rem_nxt = rem_r - {1'b0, div_r};
          quo_nxt = {quo_r[2:0], 1'b1};
        end else begin
          quo_nxt = {quo_r[2:0], 1'b0};
        end
        div_nxt  = div_r >> 1;
        step_nxt = step_r - 2'd1;
        if (step_r == 2'd0) begin
          lvl_nxt   = chs_pkg::level_clamp(quo_nxt);
          state_nxt = chs_pkg::BK_EMIT;
        end
      end

      chs_pkg::BK_EMIT: begin
        // Load the result slot once it is empty or being drained.
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt       = 1'b1;
          out_nxt.hit_count   = count_r;
          out_nxt.shade_level = lvl_r;
          out_nxt.glyph       = chs_pkg::glyph_of(lvl_r);
          out_nxt.peak_count  = peak_r;
          state_nxt           = chs_pkg::BK_IDLE;
        end
      end

      default: begin
        state_nxt = chs_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state_r == chs_pkg::BK_IDLE) && cmd_valid && cmd.in_range) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
    if (mem_we) begin
      mem[cur_addr] <= upd_count;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    count_r <= count_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    quo_r   <= quo_nxt;
    step_r  <= step_nxt;
    lvl_r   <= lvl_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chs_pkg::BK_IDLE;
      peak_r      <= 8'd0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      peak_r      <= peak_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CHS_ASSERT_HOLDS(a_count_le_peak, !out_valid_r || (out_r.hit_count <= out_r.peak_count), "result count above peak")
  `CHS_ASSERT_IMPLIES(a_level_sane, out_valid_r, (out_r.shade_level <= chs_pkg::LEVEL_MAX) && ((out_r.shade_level == 4'd0) || (out_r.hit_count != 8'd0)), "bad shade level")
  `CHS_ASSERT_NEXT(a_clear_wipes, (state_r == chs_pkg::BK_UPDATE) && (cur_r.op == chs_pkg::OP_CLEAR), (peak_r == 8'd0) && (vld_r == '0), "clear left state behind")
  `CHS_ASSERT_IMPLIES(a_divide_read_only, state_r == chs_pkg::BK_DIVIDE, (cur_r.op == chs_pkg::OP_READ) && (peak_r != 8'd0), "divide outside a read")

endmodule

// ----- hw/rtl/channel_activity_histogram_shader.sv -----
// ----------------------------------------------------------------------------
// channel_activity_histogram_shader
// Per-channel detector hit histogram with greyscale glyph readout.
// ----------------------------------------------------------------------------
// Items enter a two-entry command queue and are executed one at a time by the
// back end. A sample or clear passes through the back end's count fetch, update
// and result load; a read with nonzero count and peak also passes through the
// one-bit-per-cycle divider that produces the level before its result load.
// The counts live in a NUM_CHANNELS x 8 memory with one valid bit per entry,
// so reset and clear take effect at once with no sweep. A finished result
// sits in the output register while the queue keeps taking new items until full.
module channel_activity_histogram_shader #(
  parameter int NUM_CHANNELS = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  chs_in_if.sink    in_if,
  chs_out_if.source out_if
);

  logic          cmd_valid;
  logic          cmd_ready;
  chs_pkg::cmd_t cmd;

  chs_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  chs_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_if    (out_if)
  );

endmodule

// ----- sim/histogram_checker.sv -----
// ----------------------------------------------------------------------------
// histogram_checker
// Watches both channels of the histogram shader, keeps its own copy of the
// per-channel hit counts and running peak, predicts one result per accepted
// item and compares each delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module histogram_checker (
  input  logic clk,
  input  logic rst_n,
  chs_in_if    in_mon,
  chs_out_if   out_mon,
  output int   err_count,
  output int   open_count
);

  // Greyscale ramp " .:-=+*#%@", darkest last
  localparam logic [6:0] SHADE_RAMP [10] = '{
    7'h20, 7'h2E, 7'h3A, 7'h2D, 7'h3D, 7'h2B, 7'h2A, 7'h23, 7'h25, 7'h40
  };

  logic [7:0]         hit_tally [128];
  logic [7:0]         peak_tally;
  chs_pkg::out_item_t shade_queue [$];

  function automatic chs_pkg::out_item_t apply_histogram_op(input chs_pkg::in_item_t it);
    chs_pkg::out_item_t r;
    int unsigned        cnt;
    int unsigned        lvl;
    cnt = 0;
    lvl = 0;
    if (it.op == chs_pkg::OP_CLEAR) begin
      foreach (hit_tally[i]) hit_tally[i] = '0;
      peak_tally = '0;
    end else begin
      if (it.op == chs_pkg::OP_SAMPLE && it.detector_byte == chs_pkg::HIT_PATTERN &&
          hit_tally[it.channel] != chs_pkg::COUNT_MAX) begin
        hit_tally[it.channel] = hit_tally[it.channel] + 8'd1;
        if (hit_tally[it.channel] > peak_tally) peak_tally = hit_tally[it.channel];
      end
      cnt = hit_tally[it.channel];
      // Round count*9/peak half up; a nonzero count never shades blank
      if (it.op == chs_pkg::OP_READ && cnt != 0 && peak_tally != 0) begin
        lvl = (18 * cnt + peak_tally) / (2 * peak_tally);
        if (lvl == 0) lvl = 1;
        if (lvl > 9) lvl = 9;
      end
    end
    r.hit_count   = cnt[7:0];
    r.shade_level = lvl[3:0];
    r.glyph       = SHADE_RAMP[lvl];
    r.peak_count  = peak_tally;
    return r;
  endfunction

  always @(posedge clk) begin
    chs_pkg::out_item_t want;
    chs_pkg::out_item_t got;
    if (!rst_n) begin
      foreach (hit_tally[i]) hit_tally[i] = '0;
      peak_tally = '0;
      shade_queue.delete();
      err_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        shade_queue.push_back(apply_histogram_op(in_mon.data));
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (shade_queue.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("ERROR: result with nothing pending: count=%0d level=%0d glyph=%h peak=%0d",
                     got.hit_count, got.shade_level, got.glyph, got.peak_count);
        end else begin
          want = shade_queue.pop_front();
          if (want.hit_count != got.hit_count || want.shade_level != got.shade_level ||
              want.glyph != got.glyph || want.peak_count != got.peak_count) begin
            err_count++;
            if (err_count <= 10) begin
              $write("ERROR: exp count=%0d level=%0d glyph=%h peak=%0d, ",
                     want.hit_count, want.shade_level, want.glyph, want.peak_count);
              $display("got count=%0d level=%0d glyph=%h peak=%0d",
                       got.hit_count, got.shade_level, got.glyph, got.peak_count);
            end
          end
        end
      end
    end
    open_count = shade_queue.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives the histogram shader with directed and random sample, read, clear
// and no-op items under bursty input and a stalling receiver, and reports
// the verdict from the checker's failure and open counts.
// ----------------------------------------------------------------------------
module tb_top;

  logic clk = 1'b0;
  logic rst_n;
  int   err_count;
  int   open_count;
  int   burst_left = 0;
  int   n_sent = 0;
  bit   hold_req = 1'b0;

  chs_in_if  in_ch ();
  chs_out_if out_ch ();

  channel_activity_histogram_shader u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  histogram_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .err_count  (err_count),
    .open_count (open_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(input chs_pkg::op_t op, input logic [6:0] ch, input logic [7:0] det);
    chs_pkg::in_item_t it;
    it.op            = op;
    it.channel       = ch;
    it.detector_byte = det;
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    in_ch.data  = it;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    n_sent++;
  endtask

  // Receiver: switch between stall patterns; honor a long hold-off on request.
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (150) @(negedge clk);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(8, 64);
      end
      left--;
      case (mode)
        0:       out_ch.ready = 1'b1;
        1:       out_ch.ready = 1'($urandom_range(0, 1));
        2:       out_ch.ready = (left % 4 == 0);
        default: out_ch.ready = ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int         seg;
    logic [6:0] hot_base;
    logic [6:0] sat_ch;
    bit         sat_done;
    sat_done = 1'b0;
    hot_base = '0;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero peak, non-hit bytes, edges of the channel range, no-op, clear
    send(chs_pkg::OP_READ,   7'd0,   8'h01);
    send(chs_pkg::OP_SAMPLE, 7'd0,   8'h00);
    send(chs_pkg::OP_SAMPLE, 7'd0,   8'hFF);
    send(chs_pkg::OP_SAMPLE, 7'd0,   8'h01);
    send(chs_pkg::OP_SAMPLE, 7'd127, 8'h01);
    send(chs_pkg::OP_SAMPLE, 7'd127, 8'h01);
    send(chs_pkg::OP_SAMPLE, 7'd127, 8'h01);
    send(chs_pkg::OP_SAMPLE, 7'd127, 8'h03);
    send(chs_pkg::OP_SAMPLE, 7'd127, 8'h80);
    send(chs_pkg::OP_READ,   7'd127, 8'h00);
    send(chs_pkg::OP_READ,   7'd0,   8'hFF);
    send(chs_pkg::OP_READ,   7'd64,  8'h01);
    send(chs_pkg::OP_NOP,    7'd127, 8'h01);
    send(chs_pkg::OP_NOP,    7'd0,   8'h00);
    send(chs_pkg::OP_CLEAR,  7'd127, 8'hFF);
    send(chs_pkg::OP_READ,   7'd127, 8'h01);
    send(chs_pkg::OP_SAMPLE, 7'd85,  8'h01);
    send(chs_pkg::OP_SAMPLE, 7'd42,  8'hFE);
    send(chs_pkg::OP_READ,   7'd85,  8'h55);
    send(chs_pkg::OP_READ,   7'd42,  8'hAA);

    // Random: hit bursts on a small set of hot channels, reads of that set, noise
    hold_req = 1'b1;
    while (n_sent < 500) begin
      seg = $urandom_range(0, 19);
      if (seg == 0) begin
        send(chs_pkg::OP_CLEAR, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
      end else if (seg < 3) begin
        repeat ($urandom_range(1, 6))
          send(chs_pkg::op_t'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
               8'($urandom_range(0, 255)));
      end else if (seg < 12) begin
        hot_base = 7'($urandom_range(0, 127));
        repeat ($urandom_range(4, 24))
          send(chs_pkg::OP_SAMPLE, hot_base + 7'($urandom_range(0, 3)),
               ($urandom_range(0, 4) != 0) ? chs_pkg::HIT_PATTERN : 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(2, 8))
          send(chs_pkg::OP_READ, hot_base + 7'($urandom_range(0, 4)),
               8'($urandom_range(0, 255)));
      end

      // Once: saturate one channel and read it, clear, then shade a single hit against a peak of 40
      if (!sat_done && n_sent > 200) begin
        sat_done = 1'b1;
        sat_ch   = 7'($urandom_range(0, 127));
        repeat (258) send(chs_pkg::OP_SAMPLE, sat_ch, chs_pkg::HIT_PATTERN);
        send(chs_pkg::OP_READ,   sat_ch,        8'($urandom_range(0, 255)));
        send(chs_pkg::OP_CLEAR,  sat_ch,        8'($urandom_range(0, 255)));
        repeat (40) send(chs_pkg::OP_SAMPLE, sat_ch, chs_pkg::HIT_PATTERN);
        send(chs_pkg::OP_SAMPLE, sat_ch + 7'd1, chs_pkg::HIT_PATTERN);
        send(chs_pkg::OP_READ,   sat_ch + 7'd1, 8'($urandom_range(0, 255)));
        send(chs_pkg::OP_READ,   sat_ch,        8'($urandom_range(0, 255)));
        hold_req = 1'b1;
      end
    end

    in_ch.valid = 1'b0;
    while (open_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0 && open_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
